// File: rtl/blr_pkg.sv
`default_nettype none

package blr_pkg;

    // Field widths fixed by the stream payload.
    localparam int COORD_W     = 6;
    localparam int CHAR_W      = 8;
    // Decision value width: holds 2*|d| - |d| terms for 6-bit differences.
    localparam int DEC_W       = 9;
    // Entries in the descriptor queue between setup and stepping.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [CHAR_W-1:0]        t_char;
    typedef logic signed [DEC_W-1:0]  t_dec;

    // One prepared line: start point on the low major end, stop coordinate,
    // initial decision value and the two decision increments.
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord major_end;
        t_dec   d_init;
        t_dec   d_keep;
        t_dec   d_move;
        logic   steep;
        logic   minor_inc;
        t_char  ch;
    } t_line_desc;

endpackage

`default_nettype wire

// File: rtl/blr_front.sv
`default_nettype none

module blr_front
    import blr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_coord i_x_start,
    input  wire t_coord i_y_start,
    input  wire t_coord i_x_end,
    input  wire t_coord i_y_end,
    input  wire t_char  i_fill_char,
    output logic        o_desc_valid,
    input  wire         i_desc_ready,
    output t_line_desc  o_desc
);

    localparam t_coord MAX_COORD = COORD_W'(GRID_SIZE - 1);

    logic                 r_valid;
    t_line_desc           r_desc;
    t_line_desc           n_desc;
    t_coord               x1, y1, x2, y2;
    logic signed [COORD_W:0] dx, dy;
    t_coord               adx, ady;
    logic                 shallow;
    t_coord               major_abs, minor_abs;
    t_dec                 keep_step;

    // Saturate endpoints to the grid.
    always_comb begin
        x1 = (i_x_start > MAX_COORD) ? MAX_COORD : i_x_start;
        y1 = (i_y_start > MAX_COORD) ? MAX_COORD : i_y_start;
        x2 = (i_x_end   > MAX_COORD) ? MAX_COORD : i_x_end;
        y2 = (i_y_end   > MAX_COORD) ? MAX_COORD : i_y_end;
    end

    // Differences, magnitudes and octant classification.
    always_comb begin
        dx        = $signed({1'b0, x2}) - $signed({1'b0, x1});
        dy        = $signed({1'b0, y2}) - $signed({1'b0, y1});
        adx       = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady       = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        shallow   = (ady <= adx);
        major_abs = shallow ? adx : ady;
        minor_abs = shallow ? ady : adx;
        keep_step = $signed({2'b00, minor_abs, 1'b0});
    end

    // Build the line descriptor, starting from the low end of the major axis.
    always_comb begin
        n_desc.steep     = !shallow;
        n_desc.minor_inc = (dx[COORD_W] && dy[COORD_W]) ||
                           ((dx != '0) && !dx[COORD_W] && (dy != '0) && !dy[COORD_W]);
        n_desc.ch        = i_fill_char;
        n_desc.d_keep    = keep_step;
        n_desc.d_init    = keep_step - $signed({3'b000, major_abs});
        n_desc.d_move    = keep_step - $signed({2'b00, major_abs, 1'b0});
        if (shallow) begin
            if (!dx[COORD_W]) begin
                n_desc.x         = x1;
                n_desc.y         = y1;
                n_desc.major_end = x2;
            end else begin
                n_desc.x         = x2;
                n_desc.y         = y2;
                n_desc.major_end = x1;
            end
        end else begin
            if (!dy[COORD_W]) begin
                n_desc.x         = x1;
                n_desc.y         = y1;
                n_desc.major_end = y2;
            end else begin
                n_desc.x         = x2;
                n_desc.y         = y2;
                n_desc.major_end = y1;
            end
        end
    end

    // The setup register frees up whenever the queue takes its content.
    assign o_ready      = !r_valid || i_desc_ready;
    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_desc <= n_desc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/blr_queue.sv
`default_nettype none

module blr_queue
    import blr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push_valid,
    output logic       o_push_ready,
    input  wire t_line_desc i_push_desc,
    output logic       o_pop_valid,
    input  wire        i_pop_ready,
    output t_line_desc o_pop_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_line_desc       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_desc   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Descriptor storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/blr_back.sv
`default_nettype none

module blr_back
    import blr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_desc_valid,
    output logic       o_desc_ready,
    input  wire t_line_desc i_desc,
    output logic       o_valid,
    input  wire        i_ready,
    output t_coord     o_pixel_x,
    output t_coord     o_pixel_y,
    output t_char      o_pixel_char,
    output logic       o_last_pixel
);

    logic   r_busy;
    t_coord r_x;
    t_coord r_y;
    t_coord r_end;
    t_dec   r_d;
    t_dec   r_d_keep;
    t_dec   r_d_move;
    logic   r_steep;
    logic   r_inc;
    t_char  r_ch;

    logic   r_out_valid;
    t_coord r_out_x;
    t_coord r_out_y;
    t_char  r_out_ch;
    logic   r_out_last;

    logic   out_load;
    logic   cur_last;
    logic   advance;
    logic   take;
    logic   move_minor;
    t_coord n_x;
    t_coord n_y;
    t_dec   n_d;

    // Step control: the output register loads whenever it is empty or drained.
    always_comb begin
        out_load   = !r_out_valid || i_ready;
        cur_last   = (r_steep ? r_y : r_x) >= r_end;
        advance    = r_busy && out_load;
        take       = i_desc_valid && (!r_busy || (advance && cur_last));
        move_minor = r_steep ? (r_d > 0) : (r_d >= 0);
    end

    // Next position and decision value along the line.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_d = move_minor ? (r_d + r_d_move) : (r_d + r_d_keep);
        if (r_steep) begin
            n_y = r_y + 1'b1;
            if (move_minor) begin
                n_x = r_inc ? (r_x + 1'b1) : (r_x - 1'b1);
            end
        end else begin
            n_x = r_x + 1'b1;
            if (move_minor) begin
                n_y = r_inc ? (r_y + 1'b1) : (r_y - 1'b1);
            end
        end
    end

    assign o_desc_ready = take;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_busy;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (advance && cur_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Line walker registers and the output pixel register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x      <= i_desc.x;
            r_y      <= i_desc.y;
            r_end    <= i_desc.major_end;
            r_d      <= i_desc.d_init;
            r_d_keep <= i_desc.d_keep;
            r_d_move <= i_desc.d_move;
            r_steep  <= i_desc.steep;
            r_inc    <= i_desc.minor_inc;
            r_ch     <= i_desc.ch;
        end else if (advance && !cur_last) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
        end
        if (advance) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_ch   <= r_ch;
            r_out_last <= cur_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_pixel_char = r_out_ch;
    assign o_last_pixel = r_out_last;

endmodule

`default_nettype wire

// File: rtl/bresenham_line_rasterizer.sv
`default_nettype none

// Bresenham line rasterizer. Each transfer on the slave stream is one line
// command (two endpoints and a fill character); the block answers with one
// master-stream transfer per pixel, max(|dx|,|dy|)+1 of them, the final one
// marked by tlast. Endpoints above GRID_SIZE-1 are saturated to GRID_SIZE-1.
// A setup stage classifies the line and prepares the start point and
// decision terms, a two-entry descriptor queue follows, and a stepping unit
// walks the line at one pixel per cycle while the master side is ready; the
// next line's first pixel follows the previous last pixel directly. A command's
// first pixel passes the setup register, the queue, the walker registers and
// the output register.

module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18], fill_char[31:24]
    input  wire  [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_char[19:12], zero[23:20]
    output logic [23:0] o_m_axis_tdata,
    // last_pixel
    output logic        o_m_axis_tlast
);

    logic       fr_valid;
    logic       fr_ready;
    t_line_desc fr_desc;
    logic       q_valid;
    logic       q_ready;
    t_line_desc q_desc;
    t_coord     pixel_x;
    t_coord     pixel_y;
    t_char      pixel_char;

    // Command setup.
    blr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_x_start    (i_s_axis_tdata[5:0]),
        .i_y_start    (i_s_axis_tdata[11:6]),
        .i_x_end      (i_s_axis_tdata[17:12]),
        .i_y_end      (i_s_axis_tdata[23:18]),
        .i_fill_char  (i_s_axis_tdata[31:24]),
        .o_desc_valid (fr_valid),
        .i_desc_ready (fr_ready),
        .o_desc       (fr_desc)
    );

    // Descriptor queue between setup and stepping.
    blr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_desc  (fr_desc),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_desc   (q_desc)
    );

    // Pixel stepping.
    blr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (q_valid),
        .o_desc_ready (q_ready),
        .i_desc       (q_desc),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_pixel_char (pixel_char),
        .o_last_pixel (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, pixel_char, pixel_y, pixel_x};

endmodule

`default_nettype wire
